[hw/rtl/wpft_pkg.sv]
// ----------------------------------------------------------------------------
// wpft_pkg
// Shared types and constants of the wide port formation table.
// ----------------------------------------------------------------------------
package wpft_pkg;

	localparam int NUM_PHYS_DEF = 8;

	localparam int SAS_W   = 64;
	localparam int RATE_W  = 4;
	localparam int CNT_W   = 4;
	localparam int MASK_W  = 8;
	localparam int ATTR_W  = 32;
	localparam int MEMB_W  = 4;
	localparam int PHY_W   = 3;
	localparam int STAT_W  = 3;
	localparam int PIDX_W  = 3;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	localparam logic [STAT_W-1:0] ST_JOINED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_ALREADY = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOFREE  = 3'd2;
	localparam logic [STAT_W-1:0] ST_LEFT    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTMEM  = 3'd4;

	localparam logic OP_JOIN  = 1'b0;
	localparam logic OP_LEAVE = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_STRICT = 1'b0;

	typedef struct packed {
		logic [SAS_W-1:0]  att;
		logic [SAS_W-1:0]  own;
		logic [CNT_W-1:0]  cnt;
		logic [MASK_W-1:0] mask;
		logic [RATE_W-1:0] rate;
		logic [ATTR_W-1:0] attrs;
	} port_entry_t;

	localparam int ENTRY_W = $bits(port_entry_t);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [PIDX_W-1:0] port_index;
		logic [CNT_W-1:0]  count;
		logic [MASK_W-1:0] mask;
		logic [RATE_W-1:0] rate;
		logic              emptied;
	} result_t;

endpackage

[hw/rtl/wpft_ram.sv]
// ----------------------------------------------------------------------------
// wpft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/wpft_ctrl.sv]
// ----------------------------------------------------------------------------
// wpft_ctrl
// Event sequencer: membership lookup, port read-modify-write, port scan.
// ----------------------------------------------------------------------------
module wpft_ctrl import wpft_pkg::*; #(
	parameter int NUM_PHYS = NUM_PHYS_DEF,
	localparam int AW = (NUM_PHYS > 1) ? $clog2(NUM_PHYS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               strict,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [PHY_W-1:0]   phy_index,
	input  logic [SAS_W-1:0]   phy_address,
	input  logic [SAS_W-1:0]   attached_address,
	input  logic [RATE_W-1:0]  link_rate,
	input  logic [ATTR_W-1:0]  attrs,
	output logic               done,
	output result_t            res,
	output logic               p_we,
	output logic [AW-1:0]      p_waddr,
	output logic [ENTRY_W-1:0] p_wdata,
	output logic               p_re,
	output logic [AW-1:0]      p_raddr,
	input  logic [ENTRY_W-1:0] p_rdata,
	output logic               m_we,
	output logic [AW-1:0]      m_waddr,
	output logic [MEMB_W-1:0]  m_wdata,
	output logic               m_re,
	output logic [AW-1:0]      m_raddr,
	input  logic [MEMB_W-1:0]  m_rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MRD  = 3'd1;
	localparam logic [2:0] S_PRD  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_SEND = 3'd4;
	localparam logic [2:0] S_FRD  = 3'd5;

	localparam logic [MEMB_W:0]   NP     = (MEMB_W+1)'(NUM_PHYS);
	localparam logic [AW-1:0]     LAST   = AW'(NUM_PHYS - 1);
	localparam logic [MASK_W-1:0] ONE_M  = MASK_W'(1);

	logic [2:0]        state_q;
	logic              op_q;
	logic [PHY_W-1:0]  phy_q;
	logic [SAS_W-1:0]  own_q;
	logic [SAS_W-1:0]  att_q;
	logic [RATE_W-1:0] rate_q;
	logic [ATTR_W-1:0] attrs_q;
	logic [AW-1:0]     cur_q;
	logic [AW-1:0]     scan_q;
	logic              rd_s1;
	logic [AW-1:0]     idx_s1;
	logic              mfnd_q;
	logic [AW-1:0]     midx_q;
	logic              ffnd_q;
	logic [AW-1:0]     fidx_q;
	logic [AW-1:0]     sel_q;
	logic              sel_free_q;
	logic              pvld_q [NUM_PHYS];
	logic              mvld_q [NUM_PHYS];
	logic              pv_s1;
	logic              mv_s1;
	logic              done_q;
	result_t           res_q;

	port_entry_t       pe;
	port_entry_t       lv;
	port_entry_t       jn;
	logic [MEMB_W-1:0] cur_m;
	logic              has;
	logic [AW-1:0]     cur_idx;
	logic              out_rng;
	logic [MASK_W-1:0] bit_m;
	logic              match_cur;
	logic              hitm;
	logic              hitf;
	logic              nmf;
	logic              nff;
	logic [AW-1:0]     nmidx;
	logic [AW-1:0]     nfidx;

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign res  = res_q;

	assign pe      = pv_s1 ? port_entry_t'(p_rdata) : '0;
	assign cur_m   = mv_s1 ? m_rdata : '0;
	assign has     = (cur_m != '0) && ({1'b0, cur_m} <= NP);
	assign cur_idx = AW'(cur_m - MEMB_W'(1));
	assign out_rng = (MEMB_W+1)'(phy_index) >= NP;
	assign bit_m   = ONE_M << phy_q;

	assign match_cur = (pe.own == own_q) && (!strict || (pe.att == att_q));
	assign hitm = rd_s1 && (pe.att != '0) && match_cur && (pe.cnt != '0);
	assign hitf = rd_s1 && (pe.att == '0) && (pe.cnt == '0);
	assign nmf   = mfnd_q || hitm;
	assign nff   = ffnd_q || hitf;
	assign nmidx = mfnd_q ? midx_q : idx_s1;
	assign nfidx = ffnd_q ? fidx_q : idx_s1;

	always_comb begin
		lv = pe;
		if (pe.cnt != '0) begin
			lv.cnt = pe.cnt - CNT_W'(1);
		end
		lv.mask = pe.mask & ~bit_m;
		if (lv.cnt == '0) begin
			lv.att   = '0;
			lv.own   = '0;
			lv.attrs = '0;
			lv.mask  = '0;
		end
	end

	always_comb begin
		jn = pe;
		if (sel_free_q) begin
			jn.att = att_q;
		end
		jn.cnt  = pe.cnt + CNT_W'(1);
		jn.mask = pe.mask | bit_m;
		if (pe.own == '0) begin
			jn.own   = own_q;
			jn.attrs = attrs_q;
			jn.rate  = rate_q;
		end else if (rate_q < pe.rate) begin
			jn.rate = rate_q;
		end
	end

	always_comb begin
		p_we    = 1'b0;
		p_waddr = cur_q;
		p_wdata = lv;
		p_re    = 1'b0;
		p_raddr = cur_idx;
		m_we    = 1'b0;
		m_waddr = AW'(phy_q);
		m_wdata = '0;
		m_re    = 1'b0;
		m_raddr = AW'(phy_index);
		case (state_q)
			S_IDLE: begin
				m_re = start && !out_rng;
			end
			S_MRD: begin
				p_re = has;
			end
			S_PRD: begin
				if (op_q == OP_LEAVE || !match_cur) begin
					p_we = 1'b1;
					m_we = 1'b1;
				end
			end
			S_SCAN: begin
				p_re    = 1'b1;
				p_raddr = scan_q;
			end
			S_SEND: begin
				p_re    = nmf || nff;
				p_raddr = nmf ? nmidx : nfidx;
			end
			S_FRD: begin
				p_we    = 1'b1;
				p_waddr = sel_q;
				p_wdata = jn;
				m_we    = 1'b1;
				m_wdata = MEMB_W'(sel_q) + MEMB_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			rd_s1   <= 1'b0;
			mfnd_q  <= 1'b0;
			ffnd_q  <= 1'b0;
			pv_s1   <= 1'b0;
			mv_s1   <= 1'b0;
			for (int i = 0; i < NUM_PHYS; i++) begin
				pvld_q[i] <= 1'b0;
				mvld_q[i] <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
			if (p_we) begin
				pvld_q[p_waddr] <= 1'b1;
			end
			if (m_we) begin
				mvld_q[m_waddr] <= 1'b1;
			end
			if (p_re) begin
				pv_s1 <= pvld_q[p_raddr];
			end
			if (m_re) begin
				mv_s1 <= mvld_q[m_raddr];
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (out_rng) begin
							done_q <= 1'b1;
							res_q  <= '{status: ST_NOTMEM, default: '0};
						end else begin
							state_q <= S_MRD;
						end
					end
				end
				S_MRD: begin
					cur_q  <= cur_idx;
					scan_q <= '0;
					rd_s1  <= 1'b0;
					mfnd_q <= 1'b0;
					ffnd_q <= 1'b0;
					if (has) begin
						state_q <= S_PRD;
					end else if (op_q == OP_LEAVE) begin
						done_q  <= 1'b1;
						res_q   <= '{status: ST_NOTMEM, default: '0};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_PRD: begin
					if (op_q == OP_LEAVE) begin
						done_q  <= 1'b1;
						res_q   <= '{status: ST_LEFT, port_index: PIDX_W'(cur_q),
							count: lv.cnt, mask: lv.mask, rate: lv.rate,
							emptied: lv.cnt == '0};
						state_q <= S_IDLE;
					end else if (match_cur) begin
						done_q  <= 1'b1;
						res_q   <= '{status: ST_ALREADY, port_index: PIDX_W'(cur_q),
							count: pe.cnt, mask: pe.mask, rate: pe.rate,
							emptied: 1'b0};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_s1  <= 1'b1;
					idx_s1 <= scan_q;
					mfnd_q <= nmf;
					midx_q <= nmidx;
					ffnd_q <= nff;
					fidx_q <= nfidx;
					scan_q <= scan_q + AW'(1);
					if (scan_q == LAST) begin
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					rd_s1      <= 1'b0;
					sel_q      <= nmf ? nmidx : nfidx;
					sel_free_q <= !nmf;
					if (nmf || nff) begin
						state_q <= S_FRD;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{status: ST_NOFREE, default: '0};
						state_q <= S_IDLE;
					end
				end
				S_FRD: begin
					done_q  <= 1'b1;
					res_q   <= '{status: ST_JOINED, port_index: PIDX_W'(sel_q),
						count: jn.cnt, mask: jn.mask, rate: jn.rate, emptied: 1'b0};
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q    <= opcode;
			phy_q   <= phy_index;
			own_q   <= phy_address;
			att_q   <= attached_address;
			rate_q  <= link_rate;
			attrs_q <= attrs;
		end
	end

endmodule

[hw/rtl/wide_port_formation_table.sv]
// ----------------------------------------------------------------------------
// wide_port_formation_table
// Groups phys into wide ports on link up and link down events.
// ----------------------------------------------------------------------------
//  channel   signals                                   transfer
//  event     start, busy, opcode .. attr_oob_mode      start && !busy
//  result    done, status .. port_emptied              done, one cycle
//  config    psel, penable, pwrite, paddr, pwdata      psel && penable
//
//  Out-of-range phy: result straight from idle, no RAM read. Leave: member
//  read, then port read and write-back; sooner when the phy is in no port.
//  Join: done at the port read if the phy stays, else a scan of all NUM_PHYS
//  entries, after a leave write-back from any old port; no free port
//  reports sooner. The scan reads one entry a cycle from the port RAM.
//  A new event is taken in the cycle its predecessor's result is shown.
//  Reset clears both tables at once through per-entry valid bits.
//  The result is not held: the receiver takes it in its one cycle.
// ----------------------------------------------------------------------------
module wide_port_formation_table import wpft_pkg::*; #(
	parameter int NUM_PHYS = NUM_PHYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [PHY_W-1:0]   phy_index,
	input  logic [SAS_W-1:0]   phy_address,
	input  logic [SAS_W-1:0]   attached_address,
	input  logic [RATE_W-1:0]  link_rate,
	input  logic [7:0]         attr_class,
	input  logic [7:0]         attr_init_proto,
	input  logic [7:0]         attr_target_proto,
	input  logic [7:0]         attr_oob_mode,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [PIDX_W-1:0]  port_index,
	output logic [CNT_W-1:0]   port_phy_count,
	output logic [MASK_W-1:0]  port_phy_mask,
	output logic [RATE_W-1:0]  port_rate,
	output logic               port_emptied
);

	localparam int AW = (NUM_PHYS > 1) ? $clog2(NUM_PHYS) : 1;

	logic               strict_q;
	result_t            res;
	logic               p_we;
	logic [AW-1:0]      p_waddr;
	logic [ENTRY_W-1:0] p_wdata;
	logic               p_re;
	logic [AW-1:0]      p_raddr;
	logic [ENTRY_W-1:0] p_rdata;
	logic               m_we;
	logic [AW-1:0]      m_waddr;
	logic [MEMB_W-1:0]  m_wdata;
	logic               m_re;
	logic [AW-1:0]      m_raddr;
	logic [MEMB_W-1:0]  m_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STRICT) ? {{(APB_W-1){1'b0}}, strict_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_STRICT) begin
			strict_q <= pwdata[0];
		end
	end

	assign status         = res.status;
	assign port_index     = res.port_index;
	assign port_phy_count = res.count;
	assign port_phy_mask  = res.mask;
	assign port_rate      = res.rate;
	assign port_emptied   = res.emptied;

	wpft_ctrl #(
		.NUM_PHYS(NUM_PHYS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.strict           (strict_q),
		.start            (start),
		.busy             (busy),
		.opcode           (opcode),
		.phy_index        (phy_index),
		.phy_address      (phy_address),
		.attached_address (attached_address),
		.link_rate        (link_rate),
		.attrs            ({attr_oob_mode, attr_target_proto, attr_init_proto, attr_class}),
		.done             (done),
		.res              (res),
		.p_we             (p_we),
		.p_waddr          (p_waddr),
		.p_wdata          (p_wdata),
		.p_re             (p_re),
		.p_raddr          (p_raddr),
		.p_rdata          (p_rdata),
		.m_we             (m_we),
		.m_waddr          (m_waddr),
		.m_wdata          (m_wdata),
		.m_re             (m_re),
		.m_raddr          (m_raddr),
		.m_rdata          (m_rdata)
	);

	wpft_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_PHYS)
	) u_port_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (p_re),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	wpft_ram #(
		.WIDTH(MEMB_W),
		.DEPTH(NUM_PHYS)
	) u_memb_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

endmodule

[hw/rtl/wpft_chk.sv]
// ----------------------------------------------------------------------------
// wpft_chk
// Port-level checks of the wide port formation table.
// ----------------------------------------------------------------------------
module wpft_chk import wpft_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [STAT_W-1:0] status,
	input logic [PIDX_W-1:0] port_index,
	input logic [CNT_W-1:0]  port_phy_count,
	input logic [MASK_W-1:0] port_phy_mask,
	input logic [RATE_W-1:0] port_rate,
	input logic              port_emptied
);

	// every accepted event either starts work or reports at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("event accepted without progress");

	a_count_mask: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> port_phy_count == CNT_W'($countones(port_phy_mask)))
		else $error("member count disagrees with member mask");

	a_no_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_NOFREE || status == ST_NOTMEM) |->
			port_index == '0 && port_phy_count == '0 && port_phy_mask == '0 &&
			port_rate == '0 && !port_emptied)
		else $error("portless result carries port fields");

	a_emptied: assert property (@(posedge clk) disable iff (!arst_n)
		done && port_emptied |-> status == ST_LEFT && port_phy_mask == '0)
		else $error("emptied flag on a non-emptying result");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status == ST_JOINED || status == ST_ALREADY || status == ST_NOFREE ||
			status == ST_LEFT || status == ST_NOTMEM)
		else $error("undefined status code");

endmodule

bind wide_port_formation_table wpft_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.port_index     (port_index),
	.port_phy_count (port_phy_count),
	.port_phy_mask  (port_phy_mask),
	.port_rate      (port_rate),
	.port_emptied   (port_emptied)
);
